[rtl/core/sli_pkg.sv]
// ----------------------------------------------------------------------------
// sli_pkg: shared types for the sorted list block
// Command and status codes, cell operations and the result word layout.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned ValueW  = 32;
  localparam int unsigned CountW  = 5;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CmdW    = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_DUMP   = 2'd2,
    CMD_NOP    = 2'd3
  } sli_cmd_e;

  typedef enum logic [StatusW-1:0] {
    ST_DONE     = 3'd0,
    ST_FULL     = 3'd1,
    ST_NOTFOUND = 3'd2,
    ST_ENTRY    = 3'd3,
    ST_EMPTY    = 3'd4
  } sli_status_e;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_CMP,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_ROTATE
  } sli_cell_op_e;

  typedef struct packed {
    sli_cell_op_e             op;
    logic signed [ValueW-1:0] key;
  } sli_cell_ctrl_t;

  typedef struct packed {
    logic [StatusW-1:0]       status;
    logic signed [ValueW-1:0] entry;
    logic [CountW-1:0]        count;
    logic                     last;
  } sli_result_t;

endpackage

[rtl/core/sli_if.sv]
// ----------------------------------------------------------------------------
// sli_in_if / sli_out_if: valid/ready channels of the sorted list block
// Command channel into the block and result channel out of it.
// ----------------------------------------------------------------------------
interface sli_in_if;
  logic              valid;
  logic              ready;
  logic [1:0]        cmd;
  logic signed [31:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface sli_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         status;
  logic signed [31:0] entry;
  logic [4:0]         count;
  logic               last;

  modport source (output valid, output status, output entry, output count,
                  output last, input ready);
  modport sink   (input valid, input status, input entry, input count,
                  input last, output ready);
endinterface

[rtl/core/sli_cell.sv]
// ----------------------------------------------------------------------------
// sli_cell: one slot of the sorted list
// Holds one value, compares it with the key and takes a neighbor's value.
// ----------------------------------------------------------------------------
module sli_cell
  import sli_pkg::*;
#(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  sli_cell_ctrl_t           ctrl_i,
  input  logic [CntW-1:0]          used_i,
  input  logic                     lt_left_c_i,
  input  logic                     lt_left_q_i,
  input  logic signed [ValueW-1:0] left_val_i,
  input  logic signed [ValueW-1:0] right_val_i,
  input  logic signed [ValueW-1:0] head_val_i,
  output logic signed [ValueW-1:0] val_o,
  output logic                     lt_c_o,
  output logic                     lt_q_o,
  output logic                     hit_q_o
);

  localparam logic [CntW-1:0] IdxC  = CntW'(Idx);
  localparam logic [CntW-1:0] IdxP1 = CntW'(Idx + 1);

  logic signed [ValueW-1:0] val_q, val_d;
  logic                     lt_q, hit_q;
  logic                     valid, wrap;

  assign valid  = IdxC < used_i;
  assign wrap   = IdxP1 == used_i;
  assign lt_c_o = valid && (val_q < ctrl_i.key);

  always_comb begin
    val_d = val_q;
    case (ctrl_i.op)
      CELL_INSERT: begin
        // keep the smaller prefix, place the key at the boundary, shift the rest right
        if (!lt_q) begin
          val_d = lt_left_q_i ? ctrl_i.key : left_val_i;
        end
      end
      CELL_REMOVE: begin
        if (!lt_q) begin
          val_d = right_val_i;
        end
      end
      CELL_ROTATE: begin
        val_d = wrap ? head_val_i : right_val_i;
      end
      default: begin
        val_d = val_q;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lt_q  <= 1'b0;
      hit_q <= 1'b0;
    end else if (ctrl_i.op == CELL_CMP) begin
      lt_q  <= lt_c_o;
      hit_q <= valid && (val_q == ctrl_i.key) && lt_left_c_i;
    end
  end

  assign val_o   = val_q;
  assign lt_q_o  = lt_q;
  assign hit_q_o = hit_q;

endmodule

[rtl/core/sli_out_buf.sv]
// ----------------------------------------------------------------------------
// sli_out_buf: result output register
// Holds one result word until the sink takes it.
// ----------------------------------------------------------------------------
module sli_out_buf
  import sli_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        load_i,
  input  sli_result_t res_i,
  output logic        can_load_o,
  sli_out_if.source   out_o
);

  logic        valid_q;
  sli_result_t res_q;

  assign can_load_o = !valid_q || out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (can_load_o) begin
      valid_q <= load_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (can_load_o && load_i) begin
      res_q <= res_i;
    end
  end

  assign out_o.valid  = valid_q;
  assign out_o.status = res_q.status;
  assign out_o.entry  = res_q.entry;
  assign out_o.count  = res_q.count;
  assign out_o.last   = res_q.last;

endmodule

[rtl/core/sorted_list_insert_remove_top.sv]
// ----------------------------------------------------------------------------
// sorted_list_insert_remove_top: bounded sorted list of signed words
// Insert, remove-first-equal and dump over a row of compare-and-shift cells.
// ----------------------------------------------------------------------------
// Insert, remove, no-op and empty-dump results pass S_CMP and S_UPD into the output
//   buffer; S_UPD waits while it cannot load. No new command is taken until S_IDLE;
//   a non-empty dump sends one entry word per cycle from S_DUMP while the buffer can load.
// The compare cycle registers every cell's flags; the update cycle shifts.
// Reset: list empties at once (count zero); cell values are not cleared.
module sorted_list_insert_remove_top
  import sli_pkg::*;
#(
  parameter int unsigned DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sli_in_if.sink    in_i,
  sli_out_if.source out_o
);

  localparam int unsigned CntW = $clog2(DEPTH + 1);
  localparam logic [CntW-1:0] DepthC = CntW'(DEPTH);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_UPD,
    S_DUMP
  } state_e;

  state_e          state_q;
  sli_cmd_e        cmd_q;
  logic signed [ValueW-1:0] key_q;
  logic [CntW-1:0] used_q;
  logic [CntW-1:0] idx_q;

  // cell row
  logic signed [ValueW-1:0] vals [DEPTH];
  logic [DEPTH-1:0]         lt_c, lt_q, hit_q;
  sli_cell_ctrl_t           cell_ctrl;

  logic        full, found, can_load, out_load, dump_last;
  logic [CntW-1:0] idx_p1;
  logic [CntW+CountW-1:0] used_ext;
  sli_result_t res;

  assign full      = used_q == DepthC;
  assign found     = |hit_q;
  assign idx_p1    = idx_q + 1'b1;
  assign dump_last = idx_p1 == used_q;

  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic                     lt_left_c, lt_left_q;
    logic signed [ValueW-1:0] left_val, right_val;

    if (g == 0) begin : g_head
      // the head cell sees an imaginary smaller neighbor
      assign lt_left_c = 1'b1;
      assign lt_left_q = 1'b1;
      assign left_val  = vals[0];
    end else begin : g_body
      assign lt_left_c = lt_c[g-1];
      assign lt_left_q = lt_q[g-1];
      assign left_val  = vals[g-1];
    end

    if (g == DEPTH - 1) begin : g_tail
      assign right_val = vals[g];
    end else begin : g_inner
      assign right_val = vals[g+1];
    end

    sli_cell #(
      .CntW (CntW),
      .Idx  (g)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (cell_ctrl),
      .used_i      (used_q),
      .lt_left_c_i (lt_left_c),
      .lt_left_q_i (lt_left_q),
      .left_val_i  (left_val),
      .right_val_i (right_val),
      .head_val_i  (vals[0]),
      .val_o       (vals[g]),
      .lt_c_o      (lt_c[g]),
      .lt_q_o      (lt_q[g]),
      .hit_q_o     (hit_q[g])
    );
  end

  // Drive the cell row: compare in S_CMP, apply the shift when the result
  // word can go out, rotate the row left once per dumped entry.
  always_comb begin
    cell_ctrl.key = key_q;
    cell_ctrl.op  = CELL_HOLD;
    case (state_q)
      S_CMP: begin
        cell_ctrl.op = CELL_CMP;
      end
      S_UPD: begin
        if (can_load && cmd_q == CMD_INSERT && !full) begin
          cell_ctrl.op = CELL_INSERT;
        end else if (can_load && cmd_q == CMD_REMOVE && found) begin
          cell_ctrl.op = CELL_REMOVE;
        end
      end
      S_DUMP: begin
        if (can_load) begin
          cell_ctrl.op = CELL_ROTATE;
        end
      end
      default: begin
        cell_ctrl.op = CELL_HOLD;
      end
    endcase
  end

  // Result word; count reports the list size after the operation.
  always_comb begin
    logic [CntW-1:0] used_new;
    used_new   = used_q;
    res.status = ST_DONE;
    res.entry  = '0;
    res.last   = 1'b1;
    if (state_q == S_DUMP) begin
      res.status = ST_ENTRY;
      res.entry  = vals[0];
      res.last   = dump_last;
    end else begin
      case (cmd_q)
        CMD_INSERT: begin
          if (full) begin
            res.status = ST_FULL;
          end else begin
            used_new = used_q + 1'b1;
          end
        end
        CMD_REMOVE: begin
          if (found) begin
            used_new = used_q - 1'b1;
          end else begin
            res.status = ST_NOTFOUND;
          end
        end
        CMD_DUMP: begin
          res.status = ST_EMPTY;
        end
        default: begin
          res.status = ST_DONE;
        end
      endcase
    end
    used_ext  = (CntW + CountW)'(used_new);
    res.count = used_ext[CountW-1:0];
  end

  // A non-empty dump leaves S_UPD without a word and goes on to S_DUMP.
  assign out_load = can_load &&
                    ((state_q == S_DUMP) ||
                     (state_q == S_UPD && !(cmd_q == CMD_DUMP && used_q != '0)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cmd_q   <= CMD_NOP;
      key_q   <= '0;
      used_q  <= '0;
      idx_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (in_i.valid) begin
            cmd_q   <= sli_cmd_e'(in_i.cmd);
            key_q   <= in_i.value;
            state_q <= S_CMP;
          end
        end
        S_CMP: begin
          state_q <= S_UPD;
        end
        S_UPD: begin
          idx_q <= '0;
          if (cmd_q == CMD_DUMP && used_q != '0) begin
            state_q <= S_DUMP;
          end else if (can_load) begin
            used_q  <= used_ext[CntW-1:0];
            state_q <= S_IDLE;
          end
        end
        S_DUMP: begin
          if (can_load) begin
            idx_q <= idx_p1;
            if (dump_last) begin
              state_q <= S_IDLE;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready = state_q == S_IDLE;

  sli_out_buf u_out_buf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (out_load),
    .res_i      (res),
    .can_load_o (can_load),
    .out_o      (out_o)
  );

endmodule
